// ===== rtl/timed_output_pattern_sequencer_core_defines.svh =====
// Assertion macros for the timed output pattern sequencer.
// Used by the top level; expects clk and rst_n in scope.
`ifndef TIMED_OUTPUT_PATTERN_SEQUENCER_CORE_DEFINES_SVH
`define TIMED_OUTPUT_PATTERN_SEQUENCER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define TOPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define TOPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TOPS_ASSERT_SAME(lbl, ante, cons, msg)
`define TOPS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/tops_pkg.sv =====
// Shared constants and codes for the timed output pattern sequencer.
// No dependencies.
package tops_pkg;

  localparam int MAX_STEPS_DEF     = 16;
  localparam int DURATION_BITS_DEF = 24;
  localparam int MAX_LINES         = 8;

  localparam int LINES_W    = 8;   // width of output vectors and levels
  localparam int TICK_W     = 24;  // elapsed tick counter, wraps
  localparam int DUR_IN_W   = 24;  // entry_duration field
  localparam int REQ_W      = 2;
  localparam int CNT_W      = 4;
  localparam int TAG_W      = 32;
  localparam int NOUT_W     = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_START = 2'd2,
    REQ_STOP  = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_OUTPUTS    = 1'b0,
    REG_INITIAL_LEVELS = 1'b1
  } cfg_reg_t;

endpackage

// ===== rtl/tops_table.sv =====
// Step table of the pattern sequencer: duration and output vector per step.
// Flop based, cleared by reset; one addressed read port plus the head entry.
// Depends on tops_pkg.
module tops_table #(
  parameter int MAX_STEPS = tops_pkg::MAX_STEPS_DEF,
  parameter int DUR_W     = tops_pkg::DURATION_BITS_DEF,
  localparam int AW       = $clog2(MAX_STEPS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [DUR_W-1:0]             wr_dur,
  input  logic [tops_pkg::LINES_W-1:0] wr_vec,
  input  logic [AW-1:0]                rd_addr,
  output logic [DUR_W-1:0]             rd_dur,
  output logic [tops_pkg::LINES_W-1:0] rd_vec,
  output logic [DUR_W-1:0]             head_dur,
  output logic [tops_pkg::LINES_W-1:0] head_vec
);

  logic [DUR_W-1:0]             dur_r [MAX_STEPS];
  logic [tops_pkg::LINES_W-1:0] vec_r [MAX_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_STEPS; i++) begin
        dur_r[i] <= '0;
        vec_r[i] <= '0;
      end
    end else if (wr_en) begin
      dur_r[wr_addr] <= wr_dur;
      vec_r[wr_addr] <= wr_vec;
    end
  end

  assign rd_dur   = dur_r[rd_addr];
  assign rd_vec   = vec_r[rd_addr];
  assign head_dur = dur_r[0];
  assign head_vec = vec_r[0];

endmodule

// ===== rtl/timed_output_pattern_sequencer_core.sv =====
// Timed output pattern sequencer: takes one request beat per cycle (tick, load,
// start, stop) and returns one status beat for each, in the cycle after it is taken.
// The state update and the step table read complete in the accept cycle and the
// status beat sits in an output register, so a new request is taken every cycle
// unless that register holds a beat the sink has not taken yet. The step table
// lives in flops cleared by reset, so no clearing pass is needed after reset.
// Depends on tops_pkg, tops_table and timed_output_pattern_sequencer_core_defines.svh.
`include "timed_output_pattern_sequencer_core_defines.svh"

module timed_output_pattern_sequencer_core #(
  parameter int MAX_STEPS     = tops_pkg::MAX_STEPS_DEF,
  parameter int DURATION_BITS = tops_pkg::DURATION_BITS_DEF,
  localparam int IDX_W        = $clog2(MAX_STEPS + 1),
  localparam int IN_BITS      = IDX_W + tops_pkg::DUR_IN_W + 2 * tops_pkg::LINES_W
                                + tops_pkg::CNT_W + tops_pkg::TAG_W,
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS     = tops_pkg::LINES_W + 2 + tops_pkg::TAG_W + IDX_W
                                + tops_pkg::TICK_W,
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // entry_index, entry_duration, entry_outputs, transition_count, end_tag, stop_values
  input  logic [IN_TDATA_W-1:0]           in_tdata,
  // req_type
  input  logic [tops_pkg::REQ_W-1:0]      in_tuser,
  // status channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_levels, running, done_res, done_tag, step_index, elapsed_ticks
  output logic [OUT_TDATA_W-1:0]          out_tdata,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tops_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tops_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int LW    = tops_pkg::LINES_W;
  localparam int AW    = $clog2(MAX_STEPS);
  localparam int DUR_W = (DURATION_BITS < tops_pkg::DUR_IN_W) ? DURATION_BITS
                                                               : tops_pkg::DUR_IN_W;
  // field offsets in in_tdata
  localparam int O_DUR  = IDX_W;
  localparam int O_VEC  = O_DUR + tops_pkg::DUR_IN_W;
  localparam int O_CNT  = O_VEC + LW;
  localparam int O_TAG  = O_CNT + tops_pkg::CNT_W;
  localparam int O_STOP = O_TAG + tops_pkg::TAG_W;

  // ---- input fields
  tops_pkg::req_t                req;
  logic [IDX_W-1:0]              f_idx;
  logic [tops_pkg::DUR_IN_W-1:0] f_dur;
  logic [LW-1:0]                 f_vec;
  logic [tops_pkg::CNT_W-1:0]    f_cnt;
  logic [tops_pkg::TAG_W-1:0]    f_tag;
  logic [LW-1:0]                 f_stop;

  assign req    = tops_pkg::req_t'(in_tuser);
  assign f_idx  = in_tdata[IDX_W-1:0];
  assign f_dur  = in_tdata[O_VEC-1:O_DUR];
  assign f_vec  = in_tdata[O_CNT-1:O_VEC];
  assign f_cnt  = in_tdata[O_TAG-1:O_CNT];
  assign f_tag  = in_tdata[O_STOP-1:O_TAG];
  assign f_stop = in_tdata[O_STOP+LW-1:O_STOP];

  // ---- state
  logic [DUR_W-1:0]             remain_r, remain_nxt;
  logic [AW-1:0]                step_r, step_nxt;
  logic [AW-1:0]                limit_r, limit_nxt;
  logic                         playing_r, playing_nxt;
  logic [LW-1:0]                level_r, level_nxt;
  logic [tops_pkg::TAG_W-1:0]   tag_r, tag_nxt;
  logic [tops_pkg::TICK_W-1:0]  tick_r, tick_nxt;
  logic [tops_pkg::NOUT_W-1:0]  nout_r;
  logic                         out_valid_r;
  logic [OUT_BITS-1:0]          out_data_r, out_data_nxt;
  logic                         done;

  logic in_acc;
  logic cfg_acc;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  // a register write waits while a request beat is being taken
  assign cfg_ready = !in_acc;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // ---- step table
  logic [AW:0]      adv_step;   // one bit wider so the limit compare cannot wrap
  logic             tbl_we;
  logic [DUR_W-1:0] rd_dur, head_dur;
  logic [LW-1:0]    rd_vec, head_vec;

  assign adv_step = {1'b0, step_r} + 1'b1;
  assign tbl_we   = in_acc && (req == tops_pkg::REQ_LOAD) && !playing_r
                    && (32'(f_idx) < 32'(MAX_STEPS));

  tops_table #(
    .MAX_STEPS (MAX_STEPS),
    .DUR_W     (DUR_W)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (tbl_we),
    .wr_addr  (f_idx[AW-1:0]),
    .wr_dur   (f_dur[DUR_W-1:0]),
    .wr_vec   (f_vec),
    .rd_addr  (adv_step[AW-1:0]),
    .rd_dur   (rd_dur),
    .rd_vec   (rd_vec),
    .head_dur (head_dur),
    .head_vec (head_vec)
  );

  // ---- next state
  always_comb begin
    remain_nxt  = remain_r;
    step_nxt    = step_r;
    limit_nxt   = limit_r;
    playing_nxt = playing_r;
    level_nxt   = level_r;
    tag_nxt     = tag_r;
    tick_nxt    = tick_r;
    done        = 1'b0;
    unique case (req)
      tops_pkg::REQ_TICK: begin
        tick_nxt = tick_r + 1'b1;
        if (playing_r) begin
          if (remain_r <= DUR_W'(1)) begin
            // step advance; the count saturates below MAX_STEPS, so the
            // advanced step always has a table entry
            step_nxt  = adv_step[AW-1:0];
            level_nxt = rd_vec;
            if (adv_step >= {1'b0, limit_r}) begin
              playing_nxt = 1'b0;
              done        = 1'b1;
            end else begin
              remain_nxt = rd_dur;
            end
          end else begin
            remain_nxt = remain_r - 1'b1;
          end
        end
      end
      tops_pkg::REQ_LOAD: begin
        // table write handled by tbl_we
      end
      tops_pkg::REQ_START: begin
        if (f_cnt != '0) begin
          limit_nxt   = (32'(f_cnt) > MAX_STEPS - 1) ? AW'(MAX_STEPS - 1) : AW'(f_cnt);
          step_nxt    = '0;
          level_nxt   = head_vec;
          remain_nxt  = head_dur;
          tag_nxt     = f_tag;
          tick_nxt    = '0;
          playing_nxt = 1'b1;
        end
      end
      tops_pkg::REQ_STOP: begin
        playing_nxt = 1'b0;
        level_nxt   = f_stop;
      end
      default: ;
    endcase
  end

  // active line mask, num_outputs saturated to MAX_LINES
  logic [LW-1:0] line_mask;
  always_comb begin
    for (int i = 0; i < LW; i++) begin
      line_mask[i] = (32'(i) < 32'(nout_r)) && (i < tops_pkg::MAX_LINES);
    end
  end

  assign out_data_nxt = {tick_nxt,
                         IDX_W'(step_nxt),
                         done ? tag_nxt : {tops_pkg::TAG_W{1'b0}},
                         done,
                         playing_nxt,
                         level_nxt & line_mask};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remain_r    <= '0;
      step_r      <= '0;
      limit_r     <= '0;
      playing_r   <= 1'b0;
      level_r     <= '0;
      tag_r       <= '0;
      tick_r      <= '0;
      nout_r      <= tops_pkg::NOUT_W'(tops_pkg::MAX_LINES);
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        remain_r  <= remain_nxt;
        step_r    <= step_nxt;
        limit_r   <= limit_nxt;
        playing_r <= playing_nxt;
        level_r   <= level_nxt;
        tag_r     <= tag_nxt;
        tick_r    <= tick_nxt;
      end else if (cfg_acc && cfg_index == tops_pkg::REG_INITIAL_LEVELS && !playing_r) begin
        level_r <= cfg_data;
      end
      if (cfg_acc && cfg_index == tops_pkg::REG_NUM_OUTPUTS) begin
        nout_r <= cfg_data[tops_pkg::NOUT_W-1:0];
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

  // ---- checks
  `TOPS_ASSERT_SAME(a_step_below_limit, playing_r, step_r < limit_r,
                    "playing with step at or past its limit")
  `TOPS_ASSERT_NEXT(a_stop_halts, in_acc && req == tops_pkg::REQ_STOP, !playing_r,
                    "stop did not halt playback")
  `TOPS_ASSERT_NEXT(a_idle_tick_keeps_step,
                    in_acc && req == tops_pkg::REQ_TICK && !playing_r, $stable(step_r),
                    "idle tick moved the step")
  `TOPS_ASSERT_NEXT(a_beat_follows_accept, in_acc, out_tvalid,
                    "accepted request produced no status beat")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for timed_output_pattern_sequencer_core.
// Drives request beats, predicts each status beat in a scoreboard class and checks it.
// Depends on tops_pkg and the core RTL.
`timescale 1ns / 100ps

module tb;

  localparam int IN_TDATA_W       = 88;
  localparam int OUT_TDATA_W      = 72;
  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int N_STEPS          = 16;

  // request fields, last member in the lowest bits
  typedef struct packed {
    logic [7:0]  stop_lv;
    logic [31:0] tag;
    logic [3:0]  count;
    logic [7:0]  vector;
    logic [23:0] duration;
    logic [4:0]  index;
  } req_fields_t;

  typedef struct {
    tops_pkg::req_t kind;
    req_fields_t    f;
  } request_t;

  typedef struct packed {
    logic [23:0] elapsed;
    logic [4:0]  step;
    logic [31:0] done_tag;
    logic        done;
    logic        running;
    logic [7:0]  levels;
  } status_t;

  localparam int STATUS_W = $bits(status_t);

  class sequencer_scoreboard;
    bit [23:0] dur_tbl [N_STEPS];
    bit [7:0]  vec_tbl [N_STEPS + 1];
    bit [23:0] remaining;
    bit [4:0]  step;
    bit [3:0]  limit;
    bit        playing;
    bit [7:0]  levels;
    bit [31:0] tag;
    bit [23:0] ticks;
    bit [3:0]  n_out;
    status_t   status_due [$];
    int        errors;

    function new();
      n_out = 4'd8;
    endfunction

    function int pending();
      return status_due.size();
    endfunction

    function void write_reg(tops_pkg::cfg_reg_t idx, bit [7:0] data);
      if (idx == tops_pkg::REG_NUM_OUTPUTS) begin
        n_out = data[3:0];
      end else begin
        if (!playing) levels = data;
      end
    endfunction

    // returns 0 for a load while playing or above index 16, and for a start with a zero count
    function bit note_request(request_t r);
      status_t s;
      bit      done;
      bit      effective;
      int      lines;
      done = 1'b0;
      effective = 1'b1;
      case (r.kind)
        tops_pkg::REQ_TICK: begin
          ticks++;
          if (playing) begin
            if (remaining <= 1) begin
              step++;
              if (step <= N_STEPS) levels = vec_tbl[step];
              if (step >= limit) begin
                playing = 1'b0;
                done = 1'b1;
              end else if (step < N_STEPS) begin
                remaining = dur_tbl[step];
              end else begin
                remaining = '0;
              end
            end else begin
              remaining--;
            end
          end
        end
        tops_pkg::REQ_LOAD: begin
          if (playing || r.f.index > N_STEPS) begin
            effective = 1'b0;
          end else begin
            vec_tbl[r.f.index] = r.f.vector;
            if (r.f.index < N_STEPS) dur_tbl[r.f.index] = r.f.duration;
          end
        end
        tops_pkg::REQ_START: begin
          if (r.f.count == 0) begin
            effective = 1'b0;
          end else begin
            // 4-bit count cannot exceed the last step, no saturation needed
            limit = r.f.count;
            step = '0;
            levels = vec_tbl[0];
            remaining = dur_tbl[0];
            tag = r.f.tag;
            ticks = '0;
            playing = 1'b1;
          end
        end
        tops_pkg::REQ_STOP: begin
          playing = 1'b0;
          levels = r.f.stop_lv;
        end
      endcase
      lines = (n_out > tops_pkg::MAX_LINES) ? tops_pkg::MAX_LINES : n_out;
      s.levels   = levels & 8'((1 << lines) - 1);
      s.running  = playing;
      s.done     = done;
      s.done_tag = done ? tag : '0;
      s.step     = step;
      s.elapsed  = ticks;
      status_due.push_back(s);
      return effective;
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_status(status_t got);
      status_t want;
      if (status_due.size() == 0) begin
        $error("status beat with no request outstanding");
        errors++;
        return;
      end
      want = status_due.pop_front();
      compare("out_levels", want.levels, got.levels);
      compare("running", want.running, got.running);
      compare("done_res", want.done, got.done);
      compare("done_tag", want.done_tag, got.done_tag);
      compare("step_index", want.step, got.step);
      compare("elapsed_ticks", want.elapsed, got.elapsed);
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [IN_TDATA_W-1:0]            in_tdata = '0;
  logic [tops_pkg::REQ_W-1:0]       in_tuser = tops_pkg::REQ_TICK;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]           out_tdata;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [tops_pkg::CFG_IDX_W-1:0]   cfg_index = tops_pkg::REG_NUM_OUTPUTS;
  logic [tops_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  sequencer_scoreboard sb;
  bit burst_mode = 1'b0;
  bit long_hold = 1'b0;
  int live_items = 0;
  int idle_cycles = 0;

  always #1 clk = ~clk;

  timed_output_pattern_sequencer_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic request_t rand_request(tops_pkg::req_t kind);
    request_t r;
    r.kind       = kind;
    r.f.index    = 5'($urandom_range(0, 31));
    r.f.duration = 24'($urandom);
    r.f.vector   = 8'($urandom);
    r.f.count    = 4'($urandom);
    r.f.tag      = $urandom;
    r.f.stop_lv  = 8'($urandom);
    return r;
  endfunction

  function automatic bit [23:0] pick_duration();
    if ($urandom_range(0, 19) == 0) return 24'($urandom);
    return 24'($urandom_range(0, 3));
  endfunction

  task automatic send_request(request_t r);
    int gap;
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(r.f);
    in_tuser  <= r.kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (sb.note_request(r)) live_items++;
  endtask

  task automatic send_tick();
    send_request(rand_request(tops_pkg::REQ_TICK));
  endtask

  task automatic send_load(bit [4:0] idx, bit [23:0] dur, bit [7:0] vec);
    request_t r;
    r = rand_request(tops_pkg::REQ_LOAD);
    r.f.index = idx;
    r.f.duration = dur;
    r.f.vector = vec;
    send_request(r);
  endtask

  task automatic send_start(bit [3:0] cnt, bit [31:0] tag);
    request_t r;
    r = rand_request(tops_pkg::REQ_START);
    r.f.count = cnt;
    r.f.tag = tag;
    send_request(r);
  endtask

  task automatic send_stop(bit [7:0] lv);
    request_t r;
    r = rand_request(tops_pkg::REQ_STOP);
    r.f.stop_lv = lv;
    send_request(r);
  endtask

  // drain all status beats before touching the registers
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(tops_pkg::cfg_reg_t idx, bit [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic play_pattern();
    int steps;
    int cap;
    int r;
    steps = $urandom_range(1, 15);
    for (int i = 0; i <= steps; i++) begin
      if ($urandom_range(0, 9) != 0) send_load(5'(i), pick_duration(), 8'($urandom));
    end
    if ($urandom_range(0, 9) == 0) begin
      send_load(5'($urandom_range(16, 31)), 24'($urandom), 8'($urandom));
    end
    send_start(($urandom_range(0, 19) == 0) ? 4'd0 : 4'(steps), $urandom);
    cap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : 120;
    while (sb.playing && cap > 0) begin
      r = $urandom_range(0, 99);
      if (r < 3) send_load(5'($urandom_range(0, 31)), 24'($urandom), 8'($urandom));
      else if (r < 5) send_start(4'($urandom_range(1, 15)), $urandom);
      else send_tick();
      cap--;
    end
    if (sb.playing) send_stop(8'($urandom));
  endtask

  task automatic run_random(int n);
    int target;
    int r;
    target = live_items + n;
    while (live_items < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        play_pattern();
      end else if (r < 88) begin
        repeat ($urandom_range(1, 6)) begin
          send_request(rand_request(tops_pkg::req_t'($urandom_range(0, 3))));
        end
      end else begin
        // broken sequence: start, a few beats, then cut off
        send_start(4'($urandom), $urandom);
        repeat ($urandom_range(0, 4)) send_tick();
        if ($urandom_range(0, 1)) send_stop(8'($urandom));
        else send_start(4'($urandom_range(1, 15)), $urandom);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_status(status_t'(out_tdata[STATUS_W-1:0]));
  end

  // sink side, with one long hold-off on request
  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
        out_tready <= 1'b1;
      end else begin
        stall = burst_mode ? 0 : pick_gap();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_tready <= 1'b1;
        repeat ($urandom_range(0, 6)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    bit [3:0] n;
    bit [7:0] lv;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset config, table extremes, ignored requests, restart, stop
    send_tick();
    send_stop(8'hA5);
    send_load(5'd0, 24'd0, 8'hFF);
    send_load(5'd1, 24'd1, 8'h01);
    send_load(5'd2, 24'hFFFFFF, 8'h80);
    send_load(5'd15, 24'd2, 8'h3C);
    send_load(5'd16, 24'h5A5A5A, 8'hC3);
    send_load(5'd31, 24'd7, 8'h55);
    send_load(5'd17, 24'd3, 8'hAA);
    send_start(4'd0, 32'hDEADBEEF);
    send_start(4'd2, 32'hFFFFFFFF);
    send_load(5'd0, 24'd9, 8'h0F);
    send_tick();
    send_tick();
    send_tick();
    send_start(4'd15, 32'h0);
    send_start(4'd3, 32'h12345678);
    send_tick();
    send_tick();
    send_tick();
    send_stop(8'h00);
    send_tick();

    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: begin n = 4'd0;  lv = 8'hFF; end
        1: begin n = 4'd15; lv = 8'h5A; end
        2: begin n = 4'd1;  lv = 8'hFF; end
        3: begin n = 4'd8;  lv = 8'h00; end
        default: begin n = 4'($urandom); lv = 8'($urandom); end
      endcase
      write_reg(tops_pkg::REG_NUM_OUTPUTS, {4'($urandom), n});
      write_reg(tops_pkg::REG_INITIAL_LEVELS, lv);
      burst_mode = (p == 2 || p == 5);
      if (p == 2) long_hold = 1'b1;
      run_random(200);
    end

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
